// ===== hdl/mdaddr_pkg.sv =====
package mdaddr_pkg;

   // Field widths of one request item and one response item.
   localparam int TYPE_W = 2;
   localparam int SLOT_W = 10;
   localparam int BASE_W = 32;
   localparam int SIZE_W = 16;
   localparam int DCNT_W = 4;
   localparam int VAL_W  = 32;
   localparam int ADR_W  = 32;

   // Request kinds carried on req_tuser.
   localparam logic [TYPE_W-1:0] REQ_HEADER = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_BOUND  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_INDEX  = 2'd2;

   // Request payload, slot in the lowest bits.
   typedef struct packed {
      logic signed [VAL_W-1:0]  index_value;
      logic signed [VAL_W-1:0]  upper_bound;
      logic signed [VAL_W-1:0]  lower_bound;
      logic [DCNT_W-1:0]        dim_count;
      logic [SIZE_W-1:0]        elem_size;
      logic signed [BASE_W-1:0] base_addr;
      logic [SLOT_W-1:0]        slot;
   } req_fields_type;

   // Response payload, element address in the lowest bits.
   typedef struct packed {
      logic [SLOT_W-1:0]       ref_slot;
      logic signed [ADR_W-1:0] element_address;
   } rsp_fields_type;

   // One array descriptor.
   typedef struct packed {
      logic [DCNT_W-1:0] dims;
      logic [SIZE_W-1:0] size;
      logic [BASE_W-1:0] base;
   } desc_type;

   // Lower bound and extent of one dimension.
   typedef struct packed {
      logic [VAL_W-1:0] extent;
      logic [VAL_W-1:0] lower;
   } bnd_type;

   localparam int REQ_FIELDS_W = $bits(req_fields_type);
   localparam int RSP_FIELDS_W = $bits(rsp_fields_type);
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

endpackage

// ===== hdl/multidim_array_address_calc.sv =====
// Row-major address calculator for multi-dimensional arrays.
// Request channel (req_): req_tuser gives the item kind. A header item writes
// the base address, element size and dimension count of one slot. Bound items
// then write the lower bound and extent of each dimension in turn. Index items
// carry one index at a time, in dimension order; the last index of a reference
// produces one response item on the rsp_ channel holding base + offset * size
// and the slot number. Header and bound items give no response.
// One item is processed at a time. A header writes the descriptor memory; a
// bound item reads the descriptor, then writes the bounds memory. An index
// item reads the descriptor and bounds, multiplies the running offset by the
// extent and adds index minus lower bound; the last one then multiplies by the
// element size and adds the base. Both memories have a registered read.
// Reset clears the dimension counters, the running offset and the response
// valid; the descriptor and bounds memories are not cleared and must be
// written before they are referenced.
// The response sits in an output register, so the next request is taken while
// it waits; a further response waits in its final cycle until the output
// register is free.
module multidim_array_address_calc #(
   parameter int SLOTS     = 1024,
   parameter int MAX_DIMS  = 10,
   parameter int ADDR_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // slot, base_addr, elem_size, dim_count, lower_bound, upper_bound,
   // index_value, zero pad
   input  logic [mdaddr_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // req_type
   input  logic [mdaddr_pkg::TYPE_W-1:0]        req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // element_address, ref_slot, zero pad
   output logic [mdaddr_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import mdaddr_pkg::*;

   localparam int SIDX_W    = $clog2(SLOTS);
   localparam int DIM_BITS  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int BND_AW    = SIDX_W + DIM_BITS;
   localparam int BND_DEPTH = SLOTS * (2 ** DIM_BITS);
   localparam bit SLOT_WRAP = (SLOTS < 1024);
   localparam int RECIP     = ((2 ** 20) + SLOTS - 1) / SLOTS;
   localparam int NCH       = (ADDR_BITS + 31) / 32;
   localparam int PW        = NCH * 32;
   localparam int CH_W      = (NCH > 1) ? $clog2(NCH) : 1;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SLOT = 3'd1;
   localparam logic [2:0] S_DESC = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_ACC  = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;

   function automatic logic [ADDR_BITS-1:0] sx(input logic signed [31:0] v);
      sx = ADDR_BITS'(v);
   endfunction

   // Control state.
   logic [2:0]           state_ff, state_in;
   logic [DIM_BITS-1:0]  load_pos_ff, load_pos_in;
   logic [DIM_BITS-1:0]  ref_pos_ff, ref_pos_in;
   logic [ADDR_BITS-1:0] acc_ff, acc_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Item payload and working registers.
   req_fields_type       item_ff, item_in;
   logic [TYPE_W-1:0]    kind_ff, kind_in;
   logic [SLOT_W-1:0]    q_ff, q_in;
   logic [SIDX_W-1:0]    sidx_ff, sidx_in;
   logic [DIM_BITS-1:0]  pos_ff, pos_in;
   logic                 last_ff, last_in;
   logic [ADDR_BITS-1:0] mul_a_ff, mul_a_in;
   logic [ADDR_BITS-1:0] prod_ff, prod_in;
   logic                 mul_size_ff, mul_size_in;
   logic [CH_W-1:0]      mi_ff, mi_in;
   logic [CH_W-1:0]      mj_ff, mj_in;
   rsp_fields_type       rsp_data_ff, rsp_data_in;

   // Memories.
   desc_type             desc_mem [0:SLOTS-1];
   desc_type             desc_rd_ff;
   bnd_type              bnd_mem [0:BND_DEPTH-1];
   bnd_type              bnd_rd_ff;
   logic                 desc_we, desc_re;
   desc_type             desc_wdata;
   logic                 bnd_we, bnd_re;
   logic [BND_AW-1:0]    bnd_addr;
   bnd_type              bnd_wdata;

   // Combinational helpers.
   logic                 req_fire;
   req_fields_type       req_fields;
   logic [29:0]          q_prod;
   logic [31:0]          s_diff;
   logic [SIDX_W-1:0]    s_comb;
   logic [DCNT_W-1:0]    d_eff;
   logic [DIM_BITS-1:0]  cur_pos, pos_c, next_pos;
   logic [DCNT_W:0]      next_pos_x;
   logic                 pos_wrap;
   logic [ADDR_BITS-1:0] b_val;
   logic [PW-1:0]        a_pad, b_pad, pp_wide, pp_sh;
   logic [31:0]          a_ch, b_ch;
   logic [63:0]          pp;
   logic                 mul_done;
   logic [ADDR_BITS-1:0] acc_new, addr_fin;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_fields = req_fields_type'(req_tdata[REQ_FIELDS_W-1:0]);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_data_ff);

   // Slot modulo SLOTS by reciprocal; exact for every ten-bit slot when
   // SLOTS does not exceed 1024.
   assign q_prod = 30'(req_fields.slot) * 30'(RECIP);
   assign s_diff = 32'(item_ff.slot) - 32'(q_ff) * 32'(SLOTS);
   assign s_comb = SLOT_WRAP ? SIDX_W'(s_diff) : SIDX_W'(item_ff.slot);

   // Effective dimension count and the dimension this item works on.
   always_comb begin
      if (desc_rd_ff.dims == '0) begin
         d_eff = DCNT_W'(1);
      end else if (desc_rd_ff.dims > DCNT_W'(MAX_DIMS)) begin
         d_eff = DCNT_W'(MAX_DIMS);
      end else begin
         d_eff = desc_rd_ff.dims;
      end
   end

   assign cur_pos    = (kind_ff == REQ_BOUND) ? load_pos_ff : ref_pos_ff;
   assign pos_c      = (DCNT_W'(cur_pos) >= d_eff) ? '0 : cur_pos;
   assign next_pos_x = (DCNT_W + 1)'(pos_c) + (DCNT_W + 1)'(1);
   assign pos_wrap   = (next_pos_x >= {1'b0, d_eff});
   assign next_pos   = pos_wrap ? '0 : DIM_BITS'(next_pos_x);

   // Shared multiplier: one 32 by 32 partial product per cycle, low bits kept.
   assign b_val    = mul_size_ff ? ADDR_BITS'(desc_rd_ff.size) : sx(bnd_rd_ff.extent);
   assign a_pad    = PW'(mul_a_ff);
   assign b_pad    = PW'(b_val);
   assign a_ch     = a_pad[32*mi_ff +: 32];
   assign b_ch     = b_pad[32*mj_ff +: 32];
   assign pp       = 64'(a_ch) * 64'(b_ch);
   assign pp_wide  = PW'(pp);
   assign pp_sh    = pp_wide << (32 * (int'(mi_ff) + int'(mj_ff)));
   assign mul_done = (mi_ff == CH_W'(NCH - 1));

   assign acc_new  = prod_ff + sx(item_ff.index_value) - sx(bnd_rd_ff.lower);
   assign addr_fin = prod_ff + sx(desc_rd_ff.base);

   assign bnd_addr = {sidx_ff, pos_c};

   always_comb begin
      state_in     = state_ff;
      load_pos_in  = load_pos_ff;
      ref_pos_in   = ref_pos_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      item_in      = item_ff;
      kind_in      = kind_ff;
      q_in         = q_ff;
      sidx_in      = sidx_ff;
      pos_in       = pos_ff;
      last_in      = last_ff;
      mul_a_in     = mul_a_ff;
      prod_in      = prod_ff;
      mul_size_in  = mul_size_ff;
      mi_in        = mi_ff;
      mj_in        = mj_ff;
      rsp_data_in  = rsp_data_ff;
      desc_we      = 1'b0;
      desc_re      = 1'b0;
      desc_wdata   = '{dims: item_ff.dim_count, size: item_ff.elem_size,
                       base: item_ff.base_addr};
      bnd_we       = 1'b0;
      bnd_re       = 1'b0;
      bnd_wdata    = '{extent: item_ff.upper_bound - item_ff.lower_bound + 32'sd1,
                       lower: item_ff.lower_bound};

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               item_in  = req_fields;
               kind_in  = req_tuser;
               q_in     = q_prod[29:20];
               state_in = S_SLOT;
            end
         end
         S_SLOT: begin
            sidx_in = s_comb;
            case (kind_ff)
               REQ_HEADER: begin
                  desc_we     = 1'b1;
                  load_pos_in = '0;
                  state_in    = S_IDLE;
               end
               REQ_BOUND, REQ_INDEX: begin
                  desc_re  = 1'b1;
                  state_in = S_DESC;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_DESC: begin
            if (kind_ff == REQ_BOUND) begin
               bnd_we      = 1'b1;
               load_pos_in = next_pos;
               state_in    = S_IDLE;
            end else begin
               bnd_re      = 1'b1;
               pos_in      = next_pos;
               last_in     = pos_wrap;
               mul_a_in    = (pos_c == '0) ? '0 : acc_ff;
               prod_in     = '0;
               mul_size_in = 1'b0;
               mi_in       = '0;
               mj_in       = '0;
               state_in    = S_MUL;
            end
         end
         S_MUL: begin
            prod_in = prod_ff + ADDR_BITS'(pp_sh);
            if (int'(mj_ff) == NCH - 1 - int'(mi_ff)) begin
               mj_in = '0;
               mi_in = mi_ff + CH_W'(1);
            end else begin
               mj_in = mj_ff + CH_W'(1);
            end
            if (mul_done) begin
               state_in = mul_size_ff ? S_FIN : S_ACC;
            end
         end
         S_ACC: begin
            if (last_ff) begin
               ref_pos_in  = '0;
               acc_in      = '0;
               mul_a_in    = acc_new;
               prod_in     = '0;
               mul_size_in = 1'b1;
               mi_in       = '0;
               mj_in       = '0;
               state_in    = S_MUL;
            end else begin
               acc_in     = acc_new;
               ref_pos_in = pos_ff;
               state_in   = S_IDLE;
            end
         end
         S_FIN: begin
            // Hold here while an earlier response is still waiting.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{ref_slot: item_ff.slot,
                                element_address: ADR_W'(addr_fin)};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         load_pos_ff  <= '0;
         ref_pos_ff   <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_pos_ff  <= load_pos_in;
         ref_pos_ff   <= ref_pos_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      kind_ff     <= kind_in;
      q_ff        <= q_in;
      sidx_ff     <= sidx_in;
      pos_ff      <= pos_in;
      last_ff     <= last_in;
      mul_a_ff    <= mul_a_in;
      prod_ff     <= prod_in;
      mul_size_ff <= mul_size_in;
      mi_ff       <= mi_in;
      mj_ff       <= mj_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Descriptor memory, one entry per slot.
   always_ff @(posedge clock) begin
      if (desc_we) begin
         desc_mem[s_comb] <= desc_wdata;
      end
      if (desc_re) begin
         desc_rd_ff <= desc_mem[s_comb];
      end
   end

   // Bounds memory, one row per slot and one entry per dimension.
   always_ff @(posedge clock) begin
      if (bnd_we) begin
         bnd_mem[bnd_addr] <= bnd_wdata;
      end
      if (bnd_re) begin
         bnd_rd_ff <= bnd_mem[bnd_addr];
      end
   end

endmodule
